// ----- design/grid_laplacian_stencil_defines.svh -----
// Assertion macros shared by the grid Laplacian stencil modules.
`ifndef GRID_LAPLACIAN_STENCIL_DEFINES_SVH
`define GRID_LAPLACIAN_STENCIL_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define GLST_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define GLST_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/glst_pkg.sv -----
// Package with types, constants and the microprogram of the grid Laplacian stencil.
`timescale 1ns / 1ps

package glst_pkg;

    localparam int DEF_GRID_SIZE  = 64;
    localparam int DEF_HALF_WIDTH = 3;

    localparam int COORD_W   = 6;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int RESULT_W  = 24;

    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = 3;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    localparam int POS_W     = 10;
    localparam int OFS_W     = 3;
    localparam int DIST_W    = 2;
    localparam int STEP_W    = 5;

    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int ACC_W     = PROD_W + 3;
    localparam int INV_SPLIT = COEF_W / 2;
    localparam int MUL_B_W   = INV_SPLIT + 1;
    localparam int PART_W    = ACC_W + MUL_B_W;
    localparam int SCALED_W  = PART_W + INV_SPLIT;
    localparam int FRAC_BITS = 19;
    localparam int ROUND_W   = SCALED_W + 1;
    localparam int QUOT_W    = ROUND_W - FRAC_BITS;

    localparam logic [COEF_W-1:0]   INV_SPACING_RESET = 16'd256;
    localparam logic [RESULT_W-1:0] SAT_MAX = {1'b0, {(RESULT_W-1){1'b1}}};
    localparam logic [RESULT_W-1:0] SAT_MIN = {1'b1, {(RESULT_W-1){1'b0}}};

    localparam logic [OFS_W-1:0] OFS_ZERO   = 3'b000;
    localparam logic [OFS_W-1:0] OFS_PLUS1  = 3'b001;
    localparam logic [OFS_W-1:0] OFS_PLUS2  = 3'b010;
    localparam logic [OFS_W-1:0] OFS_PLUS3  = 3'b011;
    localparam logic [OFS_W-1:0] OFS_MINUS1 = 3'b111;
    localparam logic [OFS_W-1:0] OFS_MINUS2 = 3'b110;
    localparam logic [OFS_W-1:0] OFS_MINUS3 = 3'b101;

    // First step after the tap sweep; taps beyond the half-width jump here.
    localparam logic [STEP_W-1:0] STEP_DRAIN = 5'd13;

    typedef enum logic {
        OPC_WRITE = 1'b0,
        OPC_QUERY = 1'b1
    } opcode_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_COEF_CENTER    = 3'd0,
        REG_COEF_FWD_1     = 3'd1,
        REG_COEF_FWD_2     = 3'd2,
        REG_COEF_FWD_3     = 3'd3,
        REG_COEF_BACK_1    = 3'd4,
        REG_COEF_BACK_2    = 3'd5,
        REG_COEF_BACK_3    = 3'd6,
        REG_INV_SPACING_SQ = 3'd7
    } creg_t;

    typedef logic [NUM_REGS-1:0][COEF_W-1:0] reg_file_t;

    typedef enum logic [2:0] {
        UOP_TAP    = 3'd0,
        UOP_NOP    = 3'd1,
        UOP_MUL_LO = 3'd2,
        UOP_MUL_HI = 3'd3,
        UOP_ADD    = 3'd4,
        UOP_ROUND  = 3'd5
    } uop_t;

    typedef struct packed {
        uop_t              op;
        logic [DIST_W-1:0] reach;
        logic [OFS_W-1:0]  dr;
        logic [OFS_W-1:0]  dc;
        creg_t             csel;
        logic [STEP_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic             write;
        logic             start;
        logic             tap;
        logic [OFS_W-1:0] dr;
        logic [OFS_W-1:0] dc;
        creg_t            csel;
        logic             mul_lo;
        logic             mul_hi;
        logic             add_hi;
        logic             round;
    } ctrl_t;

    function automatic uword_t tap_word(input logic [DIST_W-1:0] reach,
                                        input logic [OFS_W-1:0] dr,
                                        input logic [OFS_W-1:0] dc,
                                        input creg_t csel);
        uword_t w;
        w.op     = UOP_TAP;
        w.reach  = reach;
        w.dr     = dr;
        w.dc     = dc;
        w.csel   = csel;
        w.target = STEP_DRAIN;
        return w;
    endfunction

    function automatic uword_t op_word(input uop_t op);
        uword_t w;
        w        = '0;
        w.op     = op;
        w.csel   = REG_COEF_CENTER;
        return w;
    endfunction

    // Microprogram: centre tap, four taps per distance, drain, scale, round.
    function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
        uword_t w;
        case (step)
            5'd0:    w = tap_word(2'd0, OFS_ZERO,   OFS_ZERO,   REG_COEF_CENTER);
            5'd1:    w = tap_word(2'd1, OFS_ZERO,   OFS_PLUS1,  REG_COEF_FWD_1);
            5'd2:    w = tap_word(2'd1, OFS_PLUS1,  OFS_ZERO,   REG_COEF_FWD_1);
            5'd3:    w = tap_word(2'd1, OFS_ZERO,   OFS_MINUS1, REG_COEF_BACK_1);
            5'd4:    w = tap_word(2'd1, OFS_MINUS1, OFS_ZERO,   REG_COEF_BACK_1);
            5'd5:    w = tap_word(2'd2, OFS_ZERO,   OFS_PLUS2,  REG_COEF_FWD_2);
            5'd6:    w = tap_word(2'd2, OFS_PLUS2,  OFS_ZERO,   REG_COEF_FWD_2);
            5'd7:    w = tap_word(2'd2, OFS_ZERO,   OFS_MINUS2, REG_COEF_BACK_2);
            5'd8:    w = tap_word(2'd2, OFS_MINUS2, OFS_ZERO,   REG_COEF_BACK_2);
            5'd9:    w = tap_word(2'd3, OFS_ZERO,   OFS_PLUS3,  REG_COEF_FWD_3);
            5'd10:   w = tap_word(2'd3, OFS_PLUS3,  OFS_ZERO,   REG_COEF_FWD_3);
            5'd11:   w = tap_word(2'd3, OFS_ZERO,   OFS_MINUS3, REG_COEF_BACK_3);
            5'd12:   w = tap_word(2'd3, OFS_MINUS3, OFS_ZERO,   REG_COEF_BACK_3);
            5'd13:   w = op_word(UOP_NOP);
            5'd14:   w = op_word(UOP_NOP);
            5'd15:   w = op_word(UOP_MUL_LO);
            5'd16:   w = op_word(UOP_MUL_HI);
            5'd17:   w = op_word(UOP_ADD);
            5'd18:   w = op_word(UOP_ROUND);
            default: w = op_word(UOP_ROUND);
        endcase
        return w;
    endfunction

endpackage

// ----- design/glst_if.sv -----
// Handshake interfaces for the command and response channels.
`timescale 1ns / 1ps

interface glst_cmd_if;
    import glst_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [COORD_W-1:0]         row;
    logic [COORD_W-1:0]         col;
    logic signed [SAMPLE_W-1:0] sample_value;

    modport source (output valid, output opcode, output row, output col,
                    output sample_value, input ready);
    modport sink   (input valid, input opcode, input row, input col,
                    input sample_value, output ready);
endinterface

interface glst_rsp_if;
    import glst_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [RESULT_W-1:0] laplacian_value;
    logic                       saturated;

    modport source (output valid, output laplacian_value, output saturated,
                    input ready);
    modport sink   (input valid, input laplacian_value, input saturated,
                     output ready);
endinterface

// ----- design/glst_ram.sv -----
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module glst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/glst_regs.sv -----
// APB-style configuration registers: stencil weights and inverse spacing squared.
`timescale 1ns / 1ps

module glst_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [glst_pkg::PADDR_W-1:0] paddr,
    input  logic [glst_pkg::PDATA_W-1:0] pwdata,
    output logic [glst_pkg::PDATA_W-1:0] prdata,
    output glst_pkg::reg_file_t          cfg
);
    import glst_pkg::*;

    // All weights clear; inv_spacing_sq is the last register and resets to one.
    localparam reg_file_t REGS_RESET = {INV_SPACING_RESET, {((NUM_REGS-1)*COEF_W){1'b0}}};

    reg_file_t regs_reg;
    creg_t     reg_idx;

    assign reg_idx = creg_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= REGS_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            regs_reg[reg_idx] <= pwdata[COEF_W-1:0];
        end
    end

    assign prdata = {{(PDATA_W-COEF_W){1'b0}}, regs_reg[reg_idx]};
    assign cfg    = regs_reg;

endmodule

// ----- design/glst_seq.sv -----
// Microcode sequencer: step counter, control ROM and jump logic.
`timescale 1ns / 1ps
`include "grid_laplacian_stencil_defines.svh"

module glst_seq #(
    parameter int HALF_WIDTH = glst_pkg::DEF_HALF_WIDTH
) (
    input  logic            clk,
    input  logic            rst_n,
    glst_cmd_if.sink        cmd,
    input  logic            out_busy,
    output glst_pkg::ctrl_t ctrl
);
    import glst_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    uword_t            uw;
    logic              fire;

    assign uw        = ucode_rom(step_reg);
    assign cmd.ready = (state_reg == ST_IDLE);
    assign fire      = cmd.valid && cmd.ready;

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        ctrl        = '0;
        ctrl.write  = fire && (cmd.opcode == OPC_WRITE);
        ctrl.start  = fire && (cmd.opcode == OPC_QUERY);
        ctrl.dr     = uw.dr;
        ctrl.dc     = uw.dc;
        ctrl.csel   = uw.csel;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                case (uw.op)
                    UOP_TAP:
                    begin
                        // Distances beyond the configured half-width skip to the drain.
                        if (uw.reach > DIST_W'(HALF_WIDTH))
                        begin
                            step_next = uw.target;
                        end
                        else
                        begin
                            ctrl.tap  = 1'b1;
                            step_next = step_reg + STEP_W'(1);
                        end
                    end
                    UOP_NOP:
                    begin
                        step_next = step_reg + STEP_W'(1);
                    end
                    UOP_MUL_LO:
                    begin
                        ctrl.mul_lo = 1'b1;
                        step_next   = step_reg + STEP_W'(1);
                    end
                    UOP_MUL_HI:
                    begin
                        ctrl.mul_hi = 1'b1;
                        step_next   = step_reg + STEP_W'(1);
                    end
                    UOP_ADD:
                    begin
                        ctrl.add_hi = 1'b1;
                        step_next   = step_reg + STEP_W'(1);
                    end
                    UOP_ROUND:
                    begin
                        if (!out_busy)
                        begin
                            ctrl.round = 1'b1;
                            state_next = ST_IDLE;
                            step_next  = '0;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                        step_next  = '0;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    `GLST_ASSERT_NXT(a_busy_after_query, ctrl.start, !cmd.ready, "query start did not leave idle")
    `GLST_ASSERT_NXT(a_mul_order, ctrl.mul_lo, ctrl.mul_hi, "high partial product did not follow")
    `GLST_ASSERT_IMP(a_round_free, ctrl.round, !out_busy, "result issued into a full register")

endmodule

// ----- design/glst_dp.sv -----
// Datapath: sample memory, tap multiply-accumulate, scaling, rounding and result register.
`timescale 1ns / 1ps
`include "grid_laplacian_stencil_defines.svh"

module glst_dp #(
    parameter int GRID_SIZE = glst_pkg::DEF_GRID_SIZE
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  glst_pkg::ctrl_t                     ctrl,
    input  glst_pkg::reg_file_t                 cfg,
    input  logic [glst_pkg::COORD_W-1:0]        row,
    input  logic [glst_pkg::COORD_W-1:0]        col,
    input  logic signed [glst_pkg::SAMPLE_W-1:0] sample_value,
    output logic                                out_busy,
    glst_rsp_if.source                          rsp
);
    import glst_pkg::*;

    localparam int CW     = $clog2(GRID_SIZE);
    localparam int DEPTH  = GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);

    function automatic logic on_grid(input logic [POS_W-1:0] p);
        return !p[POS_W-1] && (p < POS_W'(GRID_SIZE));
    endfunction

    function automatic logic [ADDR_W-1:0] grid_addr(input logic [POS_W-1:0] r,
                                                     input logic [POS_W-1:0] c);
        return ADDR_W'(r[CW-1:0]) * ADDR_W'(GRID_SIZE) + ADDR_W'(c[CW-1:0]);
    endfunction

    logic [POS_W-1:0]           wr_row, wr_col, nb_row, nb_col;
    logic                       wr_ok, tap_ok, ram_we;
    logic [ADDR_W-1:0]          ram_addr;
    logic signed [SAMPLE_W-1:0] ram_rdata;

    logic [POS_W-1:0]           q_row_reg, q_col_reg;
    logic                       q_inside_reg;
    logic                       tap_valid_reg;
    logic signed [COEF_W-1:0]   tap_coef_reg;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic [MUL_B_W-1:0]         mul_b;
    logic signed [PART_W-1:0]   mul_out;
    logic signed [PART_W-1:0]   part_reg, part_next;
    logic signed [SCALED_W-1:0] scaled_reg, scaled_next;
    logic [ROUND_W-1:0]         rounded;
    logic [QUOT_W-1:0]          quot;
    logic [QUOT_W-RESULT_W:0]   quot_top;
    logic                       sat_pos, sat_neg;
    logic                       rsp_valid_reg;
    logic [RESULT_W-1:0]        rsp_value_reg, rsp_value_next;
    logic                       rsp_sat_reg;

    assign wr_row = {{(POS_W-COORD_W){1'b0}}, row};
    assign wr_col = {{(POS_W-COORD_W){1'b0}}, col};
    assign wr_ok  = on_grid(wr_row) && on_grid(wr_col);

    assign nb_row = q_row_reg + {{(POS_W-OFS_W){ctrl.dr[OFS_W-1]}}, ctrl.dr};
    assign nb_col = q_col_reg + {{(POS_W-OFS_W){ctrl.dc[OFS_W-1]}}, ctrl.dc};
    assign tap_ok = ctrl.tap && q_inside_reg && on_grid(nb_row) && on_grid(nb_col);

    // The port is free for a write only while the sequencer is idle.
    assign ram_we   = ctrl.write && wr_ok;
    assign ram_addr = ctrl.write ? grid_addr(wr_row, wr_col) : grid_addr(nb_row, nb_col);

    glst_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_grid_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (sample_value),
        .rdata (ram_rdata)
    );

    // Kept apart from any unsigned operand so the product stays a signed multiply.
    always_comb
    begin
        prod_next = '0;
        if (tap_valid_reg)
        begin
            prod_next = tap_coef_reg * ram_rdata;
        end
    end

    assign acc_next  = ctrl.start ? '0
                     : acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // One shared multiplier scales the sum by each byte of the inverse spacing in turn.
    assign mul_b   = ctrl.mul_hi
                   ? {1'b0, cfg[REG_INV_SPACING_SQ][COEF_W-1:INV_SPLIT]}
                   : {1'b0, cfg[REG_INV_SPACING_SQ][INV_SPLIT-1:0]};
    assign mul_out = acc_reg * $signed(mul_b);

    assign part_next = ctrl.mul_hi ? mul_out : part_reg;

    always_comb
    begin
        scaled_next = scaled_reg;
        if (ctrl.mul_lo)
        begin
            scaled_next = {{(SCALED_W-PART_W){mul_out[PART_W-1]}}, mul_out};
        end
        else if (ctrl.add_hi)
        begin
            scaled_next = scaled_reg + {part_reg, {INV_SPLIT{1'b0}}};
        end
    end

    // Round half up, then clip to the signed result range.
    assign rounded  = {scaled_reg[SCALED_W-1], scaled_reg}
                    + (ROUND_W'(1) << (FRAC_BITS - 1));
    assign quot     = rounded[ROUND_W-1:FRAC_BITS];
    assign quot_top = quot[QUOT_W-1:RESULT_W-1];
    assign sat_pos  = !quot[QUOT_W-1] && (|quot_top);
    assign sat_neg  = quot[QUOT_W-1] && !(&quot_top);

    always_comb
    begin
        if (sat_pos)
        begin
            rsp_value_next = SAT_MAX;
        end
        else if (sat_neg)
        begin
            rsp_value_next = SAT_MIN;
        end
        else
        begin
            rsp_value_next = quot[RESULT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_valid_reg <= 1'b0;
            prod_reg      <= '0;
            acc_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            tap_valid_reg <= tap_ok;
            prod_reg      <= prod_next;
            acc_reg       <= acc_next;
            if (ctrl.round)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            q_row_reg    <= wr_row;
            q_col_reg    <= wr_col;
            q_inside_reg <= wr_ok;
        end
        tap_coef_reg <= cfg[ctrl.csel];
        part_reg     <= part_next;
        scaled_reg   <= scaled_next;
        if (ctrl.round)
        begin
            rsp_value_reg <= rsp_value_next;
            rsp_sat_reg   <= sat_pos || sat_neg;
        end
    end

    assign out_busy            = rsp_valid_reg;
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.laplacian_value = rsp_value_reg;
    assign rsp.saturated       = rsp_sat_reg;

    `GLST_ASSERT_NXT(a_round_loads, ctrl.round, rsp_valid_reg, "result register not loaded")
    `GLST_ASSERT_IMP(a_sat_clip, rsp_valid_reg && rsp_sat_reg, (rsp_value_reg == SAT_MAX) || (rsp_value_reg == SAT_MIN), "saturated result not at a range limit")
    `GLST_ASSERT_IMP(a_outside_zero, ctrl.round && !q_inside_reg, scaled_reg == '0, "off-grid query left a nonzero sum")

endmodule

// ----- design/grid_laplacian_stencil.sv -----
// Top level of the 2-D finite-difference Laplacian stencil block.
`timescale 1ns / 1ps

// The block holds a GRID_SIZE x GRID_SIZE grid of signed 16-bit samples in a single-port
// RAM. A write transaction stores one sample and returns nothing; writes are taken back
// to back while the block is idle, and a write outside the grid is dropped. A query
// transaction returns one result: the weighted sum of the centre and of its neighbours up
// to HALF_WIDTH away along row and column (off-grid neighbours left out), scaled by
// inv_spacing_sq, rounded half up and clipped to 24 bits with the saturated flag set on
// clipping; a query outside the grid returns zero. A microprogram reads one stencil tap
// per cycle from the single RAM port, and at a HALF_WIDTH below 3 it jumps past the
// unused taps to the drain. The result is registered at the end of the run and the next
// command is taken in the cycle after; no new command is taken while a query runs. The
// result waits in an output register, so the next item is accepted while it waits; a later
// query then holds in its last step until that result has been taken. The grid memory is
// not cleared at reset: every entry a query touches must have been written first.
// Registers are to be written only while the block is idle; the block itself does not
// enforce this.
module grid_laplacian_stencil #(
    parameter int GRID_SIZE  = glst_pkg::DEF_GRID_SIZE,
    parameter int HALF_WIDTH = glst_pkg::DEF_HALF_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    glst_cmd_if.sink                     cmd,
    glst_rsp_if.source                   rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [glst_pkg::PADDR_W-1:0] paddr,
    input  logic [glst_pkg::PDATA_W-1:0] pwdata,
    output logic [glst_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import glst_pkg::*;

    reg_file_t cfg;
    ctrl_t     ctrl;
    logic      out_busy;

    assign pready = 1'b1;

    glst_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    glst_seq #(
        .HALF_WIDTH (HALF_WIDTH)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .out_busy (out_busy),
        .ctrl     (ctrl)
    );

    glst_dp #(
        .GRID_SIZE (GRID_SIZE)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .cfg          (cfg),
        .row          (cmd.row),
        .col          (cmd.col),
        .sample_value (cmd.sample_value),
        .out_busy     (out_busy),
        .rsp          (rsp)
    );

endmodule
